@@ rtl/core/segx_pkg.sv @@
// Shared constants for the segment intersection block.
`default_nettype none
package segx_pkg;
    // Number of point candidates collected from the endpoints.
    localparam int CAND_COUNT = 4;
    // Codes for the number of intersection points.
    localparam logic [1:0] HIT_NONE = 2'd0;
    localparam logic [1:0] HIT_ONE  = 2'd1;
    localparam logic [1:0] HIT_TWO  = 2'd2;
endpackage
`default_nettype wire

@@ rtl/core/segment_intersection.sv @@
// Top level of the segment intersection block.
//
// Usage: drive the eight endpoint coordinates and raise start; a request is
// taken at every clock edge where start is high and busy is low. busy is tied
// low, so one request may enter in every cycle.
// Each request produces exactly one result: done pulses for one cycle with
// hit_count and the point ports valid in that same cycle.
// A result passes through 3*COORD_BITS+9 register stages: four front stages
// (differences, products, split numerator products, numerator sums), one
// divider cell per quotient bit (3*COORD_BITS+4 cells, x and y chains side by
// side) and the output register.
// Throughput is one request per cycle.
// Reset clears every valid bit in the pipeline; no result appears for requests
// taken before reset. The receiver cannot stall, so results are never held.
// Proper crossings give the truncated quotient; other cases give the sorted
// distinct endpoints that lie on the other segment.
`default_nettype none
module segment_intersection #(
    parameter int COORD_BITS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic signed [COORD_BITS-1:0] a_x, a_y, b_x, b_y,
    input  wire logic signed [COORD_BITS-1:0] c_x, c_y, d_x, d_y,
    output logic                             done,
    output logic [1:0]                       hit_count,
    output logic signed [COORD_BITS-1:0]     first_x, first_y, second_x, second_y
);
    import segx_pkg::*;
    localparam int NW = 3 * COORD_BITS + 4;
    localparam int PW = 3 + 4 * COORD_BITS + 1;

    logic f_vld, f_prop, nxn, nyn;
    logic [1:0] f_cnt;
    logic signed [COORD_BITS-1:0] p0x, p0y, p1x, p1y;
    logic [NW-1:0] nxa, nya, dna;

    assign busy = 1'b0;

    segx_front #(.CB(COORD_BITS)) u_front (
        .clk, .rst_n, .vld_in(start),
        .ax(a_x), .ay(a_y), .bx(b_x), .by(b_y),
        .cx(c_x), .cy(c_y), .dx(d_x), .dy(d_y),
        .vld_out(f_vld), .proper_out(f_prop), .cnt_out(f_cnt),
        .p0x, .p0y, .p1x, .p1y,
        .nx_abs(nxa), .ny_abs(nya), .den_abs(dna), .nx_neg(nxn), .ny_neg(nyn)
    );

    // Two chains of divider cells; the x chain carries the side payload.
    logic          vx [NW+1];
    logic          vy [NW+1];
    logic [NW-1:0] nx [NW+1];
    logic [NW-1:0] rx [NW+1];
    logic [NW-1:0] dx [NW+1];
    logic [NW-1:0] ny [NW+1];
    logic [NW-1:0] ry [NW+1];
    logic [NW-1:0] dy [NW+1];
    logic          gx [NW+1];
    logic          gy [NW+1];
    logic [PW-1:0] px [NW+1];
    logic [0:0]    py [NW+1];

    assign vx[0] = f_vld; assign vy[0] = f_vld;
    assign nx[0] = nxa; assign ny[0] = nya;
    assign rx[0] = '0;  assign ry[0] = '0;
    assign dx[0] = dna; assign dy[0] = dna;
    assign gx[0] = nxn; assign gy[0] = nyn;
    assign px[0] = {f_prop, f_cnt, p0x, p0y, p1x, p1y, 1'b0};
    assign py[0] = 1'b0;

    for (genvar k = 0; k < NW; k++)
    begin : g_chain
        segx_div_cell #(.W(NW), .P(PW)) u_cx (
            .clk, .rst_n, .vld_in(vx[k]), .num_in(nx[k]), .rem_in(rx[k]),
            .den_in(dx[k]), .neg_in(gx[k]), .pay_in(px[k]),
            .vld_out(vx[k+1]), .num_out(nx[k+1]), .rem_out(rx[k+1]),
            .den_out(dx[k+1]), .neg_out(gx[k+1]), .pay_out(px[k+1])
        );
        segx_div_cell #(.W(NW), .P(1)) u_cy (
            .clk, .rst_n, .vld_in(vy[k]), .num_in(ny[k]), .rem_in(ry[k]),
            .den_in(dy[k]), .neg_in(gy[k]), .pay_in(py[k]),
            .vld_out(vy[k+1]), .num_out(ny[k+1]), .rem_out(ry[k+1]),
            .den_out(dy[k+1]), .neg_out(gy[k+1]), .pay_out(py[k+1])
        );
    end

    // Output stage: sign the quotients and pick the result form.
    logic [PW-1:0] pe;
    logic [NW-1:0] qx, qy;
    logic          done_reg;
    logic [1:0]    cnt_reg;
    logic signed [COORD_BITS-1:0] fx_reg, fy_reg, sx_reg, sy_reg;

    always_comb
    begin
        pe = px[NW];
        qx = gx[NW] ? NW'(-nx[NW]) : nx[NW];
        qy = gy[NW] ? NW'(-ny[NW]) : ny[NW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vx[NW] & vy[NW];
    end

    always_ff @(posedge clk)
    begin
        if (pe[PW-1])
        begin
            cnt_reg <= HIT_ONE;
            fx_reg  <= qx[COORD_BITS-1:0];
            fy_reg  <= qy[COORD_BITS-1:0];
            sx_reg  <= '0;
            sy_reg  <= '0;
        end
        else
        begin
            cnt_reg <= pe[PW-2:PW-3];
            fx_reg  <= (pe[PW-2:PW-3] != HIT_NONE) ? pe[4*COORD_BITS:3*COORD_BITS+1] : '0;
            fy_reg  <= (pe[PW-2:PW-3] != HIT_NONE) ? pe[3*COORD_BITS:2*COORD_BITS+1] : '0;
            sx_reg  <= (pe[PW-2:PW-3] == HIT_TWO) ? pe[2*COORD_BITS:COORD_BITS+1] : '0;
            sy_reg  <= (pe[PW-2:PW-3] == HIT_TWO) ? pe[COORD_BITS:1] : '0;
        end
    end

    assign done      = done_reg;
    assign hit_count = cnt_reg;
    assign first_x   = fx_reg;
    assign first_y   = fy_reg;
    assign second_x  = sx_reg;
    assign second_y  = sy_reg;
endmodule
`default_nettype wire

@@ rtl/core/segx_div_cell.sv @@
// One cell of the restoring divider chain: one quotient bit per cell.
`default_nettype none
module segx_div_cell #(
    parameter int W = 192,
    parameter int P = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           vld_in,
    input  wire logic [W-1:0]   num_in,
    input  wire logic [W-1:0]   rem_in,
    input  wire logic [W-1:0]   den_in,
    input  wire logic           neg_in,
    input  wire logic [P-1:0]   pay_in,
    output logic                vld_out,
    output logic [W-1:0]        num_out,
    output logic [W-1:0]        rem_out,
    output logic [W-1:0]        den_out,
    output logic                neg_out,
    output logic [P-1:0]        pay_out
);
    logic [W:0]   trial;
    logic [W-1:0] shifted;
    logic         vld_reg;
    logic [W-1:0] num_reg, rem_reg, den_reg;
    logic         neg_reg;
    logic [P-1:0] pay_reg;

    // Shift in the next numerator bit and try the subtraction.
    always_comb
    begin
        shifted = {rem_in[W-2:0], num_in[W-1]};
        trial   = {1'b0, shifted} - {1'b0, den_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    // The numerator register collects quotient bits at its low end.
    always_ff @(posedge clk)
    begin
        rem_reg <= trial[W] ? shifted : trial[W-1:0];
        num_reg <= {num_in[W-2:0], ~trial[W]};
        den_reg <= den_in;
        neg_reg <= neg_in;
        pay_reg <= pay_in;
    end

    assign vld_out = vld_reg;
    assign num_out = num_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign neg_out = neg_reg;
    assign pay_out = pay_reg;
endmodule
`default_nettype wire

@@ rtl/core/segx_front.sv @@
// Front stages: cross products, endpoint tests, sort and numerators.
`default_nettype none
module segx_front #(
    parameter int CB = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                vld_in,
    input  wire logic signed [CB-1:0] ax, ay, bx, by, cx, cy, dx, dy,
    output logic                     vld_out,
    output logic                     proper_out,
    output logic [1:0]               cnt_out,
    output logic signed [CB-1:0]     p0x, p0y, p1x, p1y,
    output logic [3*CB+3:0]          nx_abs, ny_abs, den_abs,
    output logic                     nx_neg, ny_neg
);
    import segx_pkg::*;
    localparam int DW = CB + 1;
    localparam int XW = 2 * CB + 3;
    localparam int NW = 3 * CB + 4;
    // Orientations are split into an unsigned low part and a signed high part.
    localparam int LW = CB + 2;
    localparam int HW = XW - LW;
    localparam int PLW = CB + LW + 1;
    localparam int PHW = CB + HW;

    // Stage 1: coordinate differences.
    logic s1_vld_reg;
    logic signed [DW-1:0] dcdx_reg, dcdy_reg, dabx_reg, daby_reg;
    logic signed [DW-1:0] cax_reg, cay_reg, cbx_reg, cby_reg;
    logic signed [DW-1:0] acx_reg, acy_reg, adx_reg, ady_reg;
    logic signed [DW-1:0] bcx_reg, bcy_reg, bdx_reg, bdy_reg;
    logic signed [CB-1:0] s1a_reg [4];
    logic signed [CB-1:0] s1b_reg [4];
    // Stage 2 products.
    logic s2_vld_reg;
    logic signed [XW-1:0] oa_reg, ob_reg, oc_reg, od_reg;
    logic signed [XW-1:0] dta_reg, dtb_reg, dtc_reg, dtd_reg;
    logic signed [CB-1:0] s2a_reg [4];
    logic signed [CB-1:0] s2b_reg [4];
    // Stage 3.
    logic s3_vld_reg, s3_prop_reg;
    logic [1:0] s3_cnt_reg;
    logic signed [CB-1:0] q0x_reg, q0y_reg, q1x_reg, q1y_reg;
    logic signed [PLW-1:0] axl_reg, ayl_reg, bxl_reg, byl_reg;
    logic signed [PHW-1:0] axh_reg, ayh_reg, bxh_reg, byh_reg;
    logic signed [NW-1:0] dn3_reg;
    // Stage 4.
    logic s4_vld_reg, s4_prop_reg;
    logic [1:0] s4_cnt_reg;
    logic signed [CB-1:0] r0x_reg, r0y_reg, r1x_reg, r1y_reg;
    logic signed [NW-1:0] nx_reg, ny_reg, dn_reg;

    function automatic logic signed [DW-1:0] sub1(input logic signed [CB-1:0] p,
                                                 input logic signed [CB-1:0] q);
        sub1 = DW'(p) - DW'(q);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= vld_in;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dcdx_reg <= sub1(dx, cx); dcdy_reg <= sub1(dy, cy);
        dabx_reg <= sub1(bx, ax); daby_reg <= sub1(by, ay);
        cax_reg <= sub1(ax, cx); cay_reg <= sub1(ay, cy);
        cbx_reg <= sub1(bx, cx); cby_reg <= sub1(by, cy);
        acx_reg <= sub1(cx, ax); acy_reg <= sub1(cy, ay);
        adx_reg <= sub1(dx, ax); ady_reg <= sub1(dy, ay);
        bcx_reg <= sub1(cx, bx); bcy_reg <= sub1(cy, by);
        bdx_reg <= sub1(dx, bx); bdy_reg <= sub1(dy, by);
        s1a_reg[0] <= ax; s1a_reg[1] <= ay; s1a_reg[2] <= bx; s1a_reg[3] <= by;
        s1b_reg[0] <= cx; s1b_reg[1] <= cy; s1b_reg[2] <= dx; s1b_reg[3] <= dy;
    end

    // Stage 2: orientations and dot products of the endpoint tests.
    always_ff @(posedge clk)
    begin
        oa_reg <= XW'(dcdx_reg * cay_reg) - XW'(dcdy_reg * cax_reg);
        ob_reg <= XW'(dcdx_reg * cby_reg) - XW'(dcdy_reg * cbx_reg);
        oc_reg <= XW'(dabx_reg * acy_reg) - XW'(daby_reg * acx_reg);
        od_reg <= XW'(dabx_reg * ady_reg) - XW'(daby_reg * adx_reg);
        // For point P on segment S-E: (S-P).(E-P).
        dta_reg <= XW'(cax_reg * (cax_reg - dcdx_reg)) + XW'(cay_reg * (cay_reg - dcdy_reg));
        dtb_reg <= XW'(cbx_reg * (cbx_reg - dcdx_reg)) + XW'(cby_reg * (cby_reg - dcdy_reg));
        dtc_reg <= XW'(acx_reg * bcx_reg) + XW'(acy_reg * bcy_reg);
        dtd_reg <= XW'(adx_reg * bdx_reg) + XW'(ady_reg * bdy_reg);
        s2a_reg <= s1a_reg;
        s2b_reg <= s1b_reg;
    end

    // Stage 3: classification, point selection and split numerator products.
    logic sa, sb, sc, sd, pa, pb, pc, pd;
    logic signed [CB-1:0] cxs [CAND_COUNT];
    logic signed [CB-1:0] cys [CAND_COUNT];
    logic [CAND_COUNT-1:0] hv;
    logic signed [CB-1:0] m0x, m0y, m1x, m1y;
    logic f0, f1;
    logic [1:0] ucnt;
    logic signed [LW:0]   oal, obl;
    logic signed [HW-1:0] oah, obh;

    function automatic logic lt(input logic signed [CB-1:0] ux, uy, vx, vy);
        lt = (ux < vx) || (ux == vx && uy < vy);
    endfunction

    assign oal = $signed({1'b0, oa_reg[LW-1:0]});
    assign obl = $signed({1'b0, ob_reg[LW-1:0]});
    assign oah = oa_reg[XW-1:LW];
    assign obh = ob_reg[XW-1:LW];

    always_comb
    begin
        sa = (oa_reg < 0) != (ob_reg < 0) && oa_reg != 0 && ob_reg != 0;
        sb = (oc_reg < 0) != (od_reg < 0) && oc_reg != 0 && od_reg != 0;
        pa = (oa_reg == 0) && (dta_reg <= 0);
        pb = (ob_reg == 0) && (dtb_reg <= 0);
        pc = (oc_reg == 0) && (dtc_reg <= 0);
        pd = (od_reg == 0) && (dtd_reg <= 0);
        sc = sa && sb;
        sd = 1'b0;
        hv = {pd, pc, pb, pa};
        cxs[0] = s2a_reg[0]; cys[0] = s2a_reg[1];
        cxs[1] = s2a_reg[2]; cys[1] = s2a_reg[3];
        cxs[2] = s2b_reg[0]; cys[2] = s2b_reg[1];
        cxs[3] = s2b_reg[2]; cys[3] = s2b_reg[3];
        // Smallest valid point, then smallest valid point above it.
        m0x = '0; m0y = '0; f0 = 1'b0;
        for (int i = 0; i < CAND_COUNT; i++)
        begin
            if (hv[i] && (!f0 || lt(cxs[i], cys[i], m0x, m0y)))
            begin
                m0x = cxs[i]; m0y = cys[i]; f0 = 1'b1;
            end
        end
        m1x = '0; m1y = '0; f1 = 1'b0;
        for (int i = 0; i < CAND_COUNT; i++)
        begin
            if (hv[i] && lt(m0x, m0y, cxs[i], cys[i])
                && (!f1 || lt(cxs[i], cys[i], m1x, m1y)))
            begin
                m1x = cxs[i]; m1y = cys[i]; f1 = 1'b1;
            end
        end
        ucnt = f1 ? HIT_TWO : (f0 ? HIT_ONE : HIT_NONE);
        if (sd)
            ucnt = HIT_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_prop_reg <= 1'b0;
            s4_prop_reg <= 1'b0;
        end
        else
        begin
            s3_prop_reg <= sc;
            s4_prop_reg <= s3_prop_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_cnt_reg <= ucnt;
        q0x_reg <= m0x; q0y_reg <= m0y; q1x_reg <= m1x; q1y_reg <= m1y;
        axl_reg <= PLW'(s2a_reg[0] * obl);
        axh_reg <= PHW'(s2a_reg[0] * obh);
        bxl_reg <= PLW'(s2a_reg[2] * oal);
        bxh_reg <= PHW'(s2a_reg[2] * oah);
        ayl_reg <= PLW'(s2a_reg[1] * obl);
        ayh_reg <= PHW'(s2a_reg[1] * obh);
        byl_reg <= PLW'(s2a_reg[3] * oal);
        byh_reg <= PHW'(s2a_reg[3] * oah);
        dn3_reg <= NW'(ob_reg) - NW'(oa_reg);
    end

    // Stage 4: recombine the split products into the numerators.
    always_ff @(posedge clk)
    begin
        s4_cnt_reg <= s3_cnt_reg;
        r0x_reg <= q0x_reg; r0y_reg <= q0y_reg; r1x_reg <= q1x_reg; r1y_reg <= q1y_reg;
        nx_reg <= (NW'(axh_reg) <<< LW) + NW'(axl_reg)
                  - (NW'(bxh_reg) <<< LW) - NW'(bxl_reg);
        ny_reg <= (NW'(ayh_reg) <<< LW) + NW'(ayl_reg)
                  - (NW'(byh_reg) <<< LW) - NW'(byl_reg);
        dn_reg <= dn3_reg;
    end

    assign vld_out    = s4_vld_reg;
    assign proper_out = s4_prop_reg;
    assign cnt_out    = s4_cnt_reg;
    assign p0x = r0x_reg; assign p0y = r0y_reg;
    assign p1x = r1x_reg; assign p1y = r1y_reg;
    assign nx_neg  = nx_reg[NW-1] != dn_reg[NW-1];
    assign ny_neg  = ny_reg[NW-1] != dn_reg[NW-1];
    assign nx_abs  = nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
    assign ny_abs  = ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
    assign den_abs = dn_reg[NW-1] ? NW'(-dn_reg) : NW'(dn_reg);
endmodule
`default_nettype wire

@@ rtl/core/segx_checker.sv @@
// Port-level checker for the segment intersection block, with its bind.
`default_nettype none
module segx_checker #(
    parameter int COORD_BITS = 32
) (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  done,
    input wire logic [1:0]            hit_count,
    input wire logic [COORD_BITS-1:0] first_x, first_y, second_x, second_y
);
    import segx_pkg::*;

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hit_count != 2'd3)) else $error("hit count out of range");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit_count == HIT_NONE |-> first_x == '0 && first_y == '0)
        else $error("empty result carries a point");
    a_second: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit_count != HIT_TWO |-> second_x == '0 && second_y == '0)
        else $error("second point without two hits");
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit_count == HIT_TWO |->
        ($signed(first_x) < $signed(second_x)) ||
        (first_x == second_x && $signed(first_y) < $signed(second_y)))
        else $error("points out of order");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy) else $error("request refused");
endmodule

bind segment_intersection segx_checker #(.COORD_BITS(COORD_BITS)) u_segx_checker (
    .clk, .rst_n, .start, .busy, .done, .hit_count,
    .first_x, .first_y, .second_x, .second_y
);
`default_nettype wire

@@ bench/segment_intersection_tb.sv @@
// Self-checking testbench for the segment intersection block.
`timescale 1ns / 1ps
module segment_intersection_tb;
    import segx_pkg::*;

    localparam int CB = 32;
    localparam int DRAIN_CYCLES = 3 + 2 * (3 * CB + 4) + 20;
    localparam int STALL_LIMIT = 8 * DRAIN_CYCLES;
    localparam int RANDOM_ITEMS = 840;
    localparam int CALM_FROM = 700;
    localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};

    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [255:0] wide_t;

    typedef struct {
        coord_t ax, ay, bx, by, cx, cy, dx, dy;
    } seg_req_t;

    typedef struct packed {
        logic [1:0] hits;
        coord_t fx, fy, sx, sy;
    } seg_res_t;

    typedef struct {
        seg_req_t req;
        bit       typed;
        seg_res_t res;
    } seg_row_t;

    logic   clk, rst_n, start;
    logic   busy, done;
    logic [1:0] hit_count;
    coord_t a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y;
    coord_t first_x, first_y, second_x, second_y;

    seg_res_t pending_hits[$];
    seg_row_t rows[$];
    int       error_count = 0;
    int       stall_cycles = 0;

    segment_intersection #(.COORD_BITS(CB)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y),
        .c_x(c_x), .c_y(c_y), .d_x(d_x), .d_y(d_y),
        .done(done), .hit_count(hit_count),
        .first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cross product of (p - o) and (q - o), exact at the wide width.
    function automatic wide_t cross_w(wide_t ox, wide_t oy, wide_t px, wide_t py,
                                      wide_t qx, wide_t qy);
        return (px - ox) * (qy - oy) - (py - oy) * (qx - ox);
    endfunction

    function automatic int sign_w(wide_t v);
        return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
    endfunction

    // True when point p lies on the closed segment from s to e.
    function automatic bit on_segment(wide_t sx, wide_t sy, wide_t ex, wide_t ey,
                                      wide_t px, wide_t py);
        wide_t dot;
        dot = (sx - px) * (ex - px) + (sy - py) * (ey - py);
        return cross_w(px, py, sx, sy, ex, ey) == 0 && dot <= 0;
    endfunction

    // Works out the intersection of AB and CD as the block should report it.
    function automatic seg_res_t predict_hits(seg_req_t r);
        seg_res_t res;
        wide_t ax, ay, bx, by, cx, cy, dx, dy;
        wide_t oa, ob, oc, od, den, tx, ty;
        wide_t lx[4], ly[4];
        int n, u;
        ax = r.ax; ay = r.ay; bx = r.bx; by = r.by;
        cx = r.cx; cy = r.cy; dx = r.dx; dy = r.dy;
        res = '{HIT_NONE, '0, '0, '0, '0};
        oa = cross_w(cx, cy, dx, dy, ax, ay);
        ob = cross_w(cx, cy, dx, dy, bx, by);
        oc = cross_w(ax, ay, bx, by, cx, cy);
        od = cross_w(ax, ay, bx, by, dx, dy);
        // A strict crossing gives one point from the truncated quotient.
        if (sign_w(oa) * sign_w(ob) < 0 && sign_w(oc) * sign_w(od) < 0)
        begin
            den = ob - oa;
            res.hits = HIT_ONE;
            res.fx = coord_t'((ax * ob - bx * oa) / den);
            res.fy = coord_t'((ay * ob - by * oa) / den);
            return res;
        end
        // Otherwise collect the endpoints that touch the other segment.
        n = 0;
        if (on_segment(cx, cy, dx, dy, ax, ay)) begin lx[n] = ax; ly[n] = ay; n++; end
        if (on_segment(cx, cy, dx, dy, bx, by)) begin lx[n] = bx; ly[n] = by; n++; end
        if (on_segment(ax, ay, bx, by, cx, cy)) begin lx[n] = cx; ly[n] = cy; n++; end
        if (on_segment(ax, ay, bx, by, dx, dy)) begin lx[n] = dx; ly[n] = dy; n++; end
        for (int i = 1; i < n; i++)
            for (int j = i; j > 0; j--)
                if (lx[j] < lx[j-1] || (lx[j] == lx[j-1] && ly[j] < ly[j-1]))
                begin
                    tx = lx[j]; lx[j] = lx[j-1]; lx[j-1] = tx;
                    ty = ly[j]; ly[j] = ly[j-1]; ly[j-1] = ty;
                end
        u = 0;
        for (int i = 0; i < n; i++)
            if (u == 0 || lx[i] != lx[u-1] || ly[i] != ly[u-1])
            begin
                lx[u] = lx[i]; ly[u] = ly[i]; u++;
            end
        if (u >= 1)
        begin
            res.hits = HIT_ONE; res.fx = coord_t'(lx[0]); res.fy = coord_t'(ly[0]);
        end
        if (u >= 2)
        begin
            res.hits = HIT_TWO; res.sx = coord_t'(lx[1]); res.sy = coord_t'(ly[1]);
        end
        return res;
    endfunction

    function automatic seg_req_t make_req(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                          coord_t cx, coord_t cy, coord_t dx, coord_t dy);
        return '{ax, ay, bx, by, cx, cy, dx, dy};
    endfunction

    function automatic coord_t pick_edge_value();
        case ($urandom_range(0, 5))
            0: return CMIN;
            1: return CMAX;
            2: return '0;
            3: return -1;
            4: return 1;
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Random request, weighted towards cases that touch or overlap.
    function automatic seg_req_t random_req();
        seg_req_t r;
        coord_t px, py, ux, uy;
        int t[4];
        case ($urandom_range(0, 9))
            0, 1, 2:
                r = make_req($urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom);
            3, 4:
                r = make_req($signed($urandom_range(0, 12)) - 6, $signed($urandom_range(0, 12)) - 6,
                             $signed($urandom_range(0, 12)) - 6, $signed($urandom_range(0, 12)) - 6,
                             $signed($urandom_range(0, 12)) - 6, $signed($urandom_range(0, 12)) - 6,
                             $signed($urandom_range(0, 12)) - 6, $signed($urandom_range(0, 12)) - 6);
            5, 6:
            begin
                // Four points on one line through a random origin.
                px = $signed($urandom_range(0, 2000000)) - 1000000;
                py = $signed($urandom_range(0, 2000000)) - 1000000;
                ux = $signed($urandom_range(0, 10)) - 5;
                uy = $signed($urandom_range(0, 10)) - 5;
                for (int i = 0; i < 4; i++) t[i] = $signed($urandom_range(0, 20)) - 10;
                r = make_req(px + t[0] * ux, py + t[0] * uy, px + t[1] * ux, py + t[1] * uy,
                             px + t[2] * ux, py + t[2] * uy, px + t[3] * ux, py + t[3] * uy);
            end
            7:
            begin
                // Segments straddling a shared region so that they usually cross.
                r = make_req(-$signed($urandom_range(1, 1000000)), -$signed($urandom_range(0, 1000000)),
                             $signed($urandom_range(1, 1000000)), $signed($urandom_range(0, 1000000)),
                             -$signed($urandom_range(1, 1000000)), $signed($urandom_range(1, 1000000)),
                             $signed($urandom_range(1, 1000000)), -$signed($urandom_range(1, 1000000)));
            end
            8:
            begin
                // One segment collapsed to a point, often on the other.
                r = make_req($signed($urandom_range(0, 8)) - 4, $signed($urandom_range(0, 8)) - 4,
                             0, 0, $signed($urandom_range(0, 16)) - 8, $signed($urandom_range(0, 16)) - 8,
                             $signed($urandom_range(0, 16)) - 8, $signed($urandom_range(0, 16)) - 8);
                r.bx = r.ax; r.by = r.ay;
                if ($urandom_range(0, 1))
                begin
                    {r.ax, r.ay, r.bx, r.by, r.cx, r.cy, r.dx, r.dy} =
                        {r.cx, r.cy, r.dx, r.dy, r.ax, r.ay, r.bx, r.by};
                end
            end
            default:
                r = make_req(pick_edge_value(), pick_edge_value(), pick_edge_value(),
                             pick_edge_value(), pick_edge_value(), pick_edge_value(),
                             pick_edge_value(), pick_edge_value());
        endcase
        return r;
    endfunction

    // Directed rows; results are typed in where they are obvious.
    function automatic void add_row(seg_req_t req, bit typed, seg_res_t res);
        seg_row_t row;
        row = '{req, typed, res};
        rows.insert(rows.size(), row);
    endfunction

    task automatic send_req(seg_req_t r);
        a_x <= r.ax; a_y <= r.ay; b_x <= r.bx; b_y <= r.by;
        c_x <= r.cx; c_y <= r.cy; d_x <= r.dx; d_y <= r.dy;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_hits.insert(pending_hits.size(), predict_hits(r));
    endtask

    task automatic idle_burst();
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
    endtask

    // Result checker: every done pulse is matched against the oldest expectation.
    always @(posedge clk)
    begin
        seg_res_t want;
        if (rst_n && done)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("unexpected result: hit_count %0d", hit_count);
                error_count++;
            end
            else
            begin
                want = pending_hits.pop_front();
                if (hit_count !== want.hits)
                begin
                    $error("hit_count: expected %0d, got %0d", want.hits, hit_count);
                    error_count++;
                end
                if (first_x !== want.fx)
                begin
                    $error("first_x: expected %0d, got %0d", want.fx, first_x);
                    error_count++;
                end
                if (first_y !== want.fy)
                begin
                    $error("first_y: expected %0d, got %0d", want.fy, first_y);
                    error_count++;
                end
                if (second_x !== want.sx)
                begin
                    $error("second_x: expected %0d, got %0d", want.sx, second_x);
                    error_count++;
                end
                if (second_y !== want.sy)
                begin
                    $error("second_y: expected %0d, got %0d", want.sy, second_y);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("segment_intersection_tb: errors");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        seg_res_t none_res;
        seg_res_t chk;
        seg_req_t r;
        none_res = '{HIT_NONE, '0, '0, '0, '0};
        rst_n = 1'b0;
        start = 1'b0;
        {a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y} = '0;

        add_row(make_req(0, 0, 0, 0, 0, 0, 0, 0), 1, '{HIT_ONE, 0, 0, 0, 0});
        add_row(make_req(0, 0, 10, 0, 0, 5, 10, 5), 1, none_res);
        add_row(make_req(0, 0, 10, 0, 10, 0, 10, 10), 1, '{HIT_ONE, 10, 0, 0, 0});
        add_row(make_req(0, 0, 10, 0, 5, 0, 20, 0), 1, '{HIT_TWO, 5, 0, 10, 0});
        add_row(make_req(10, 0, 0, 0, 0, 0, 10, 0), 1, '{HIT_TWO, 0, 0, 10, 0});
        add_row(make_req(0, 0, 4, 0, 6, 0, 9, 0), 1, none_res);
        add_row(make_req(2, 2, 2, 2, 0, 0, 4, 4), 1, '{HIT_ONE, 2, 2, 0, 0});
        add_row(make_req(0, 0, 4, 4, 3, 1, 3, 1), 1, none_res);
        add_row(make_req(0, 0, 3, 1, 0, 1, 3, 0), 0, none_res);
        add_row(make_req(0, 0, -3, -1, 0, -1, -3, 0), 0, none_res);
        add_row(make_req(0, 0, 2, 2, 0, 2, 2, 0), 1, '{HIT_ONE, 1, 1, 0, 0});
        add_row(make_req(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN), 0, none_res);
        add_row(make_req(CMIN, 0, CMAX, 0, CMIN, 0, CMAX, 0), 1,
                '{HIT_TWO, CMIN, 0, CMAX, 0});
        add_row(make_req(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX), 1,
                '{HIT_ONE, CMAX, CMAX, 0, 0});
        add_row(make_req(CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX), 1, none_res);
        add_row(make_req(CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX), 0, none_res);
        add_row(make_req(-1, -1, -1, -1, -1, -1, -1, -1), 1, '{HIT_ONE, -1, -1, 0, 0});
        add_row(make_req(0, 0, 1, 3, 1, 0, 0, 2), 0, none_res);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: typed rows must also agree with the predictor.
        foreach (rows[i])
        begin
            if (rows[i].typed)
            begin
                chk = predict_hits(rows[i].req);
                if (chk !== rows[i].res)
                begin
                    $error("directed row %0d: hit_count expected %0d, predicted %0d",
                           i, rows[i].res.hits, chk.hits);
                    error_count++;
                end
            end
            send_req(rows[i].req);
            if ($urandom_range(0, 2) == 0) idle_burst();
        end

        // Hold off until the pipe has drained once.
        start <= 1'b0;
        while (pending_hits.size() != 0) @(posedge clk);

        // Random part; no gaps in a middle stretch or near the end.
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            r = random_req();
            send_req(r);
            if (k < CALM_FROM && !(k >= 300 && k < 400) && $urandom_range(0, 3) == 0)
                idle_burst();
        end
        start <= 1'b0;

        while (pending_hits.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("segment_intersection_tb: clean");
        else
            $display("segment_intersection_tb: errors");
        $finish;
    end
endmodule
